FILE: rtl/tomq_pkg.sv
// Shared types and constants for the timestamp-ordered message queue.
// Holds field widths, command and status codes, parameter defaults and the
// sequencer state type. No dependencies.
package tomq_pkg;

    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_HANDLE_BITS = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_REM_OUT,
        ST_RESULT
    } tomq_state_t;

endpackage

FILE: rtl/tomq_ram.sv
// Entry store for the message queue: one write port and one read port with
// registered read data. Depends on tomq_pkg for parameter defaults only.
module tomq_ram #(
    parameter int DEPTH  = tomq_pkg::DEF_QUEUE_DEPTH,
    parameter int WIDTH  = tomq_pkg::TIME_W + tomq_pkg::HANDLE_W,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/timestamp_ordered_message_queue.sv
// Timestamp-ordered message queue, top level. Uses tomq_pkg and tomq_ram.
//
// Keeps up to QUEUE_DEPTH entries sorted by timestamp in a circular buffer
// held in one single-port-write, single-port-read memory; equal timestamps
// leave in arrival order. A request on the s_ side is insert (s_tuser = 0) or
// remove earliest (s_tuser = 1); each request gives exactly one result on the
// m_ side. A remove passes through ST_REM_OUT to ST_RESULT, and a request
// that is refused (remove from empty, insert into full) or an insert into an
// empty queue goes straight from ST_IDLE to ST_RESULT.
// An insert into a non-empty queue walks back from the latest entry, moving
// one entry up per cycle through the memory's single read and write port
// past every held entry later than the new timestamp. The result register
// lets the next request be accepted while a result still waits on m_tready.
// The memory needs no clearing after reset.
module timestamp_ordered_message_queue #(
    parameter int QUEUE_DEPTH = tomq_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = tomq_pkg::DEF_HANDLE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key_time[31:0], message_handle[47:32]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_time[31:0], out_handle[47:32], now_empty[48], entry_count[53:49], zero
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser    // status[1:0]
);

    import tomq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int HS_W  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int WORD_W = TIME_W + HS_W;
    localparam logic [PTR_W:0]   DEPTH_P  = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    tomq_state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic [TIME_W-1:0]   key_reg, key_next;
    logic [HS_W-1:0]     hnd_reg, hnd_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TIME_W-1:0]   res_time_reg, res_time_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                m_valid_reg, m_valid_next;
    logic [55:0]         m_data_reg, m_data_next;
    logic [1:0]          m_user_reg, m_user_next;

    logic              wr_en, rd_en;
    logic [PTR_W-1:0]  wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;
    logic [TIME_W-1:0] rd_time;
    logic [HS_W-1:0]   rd_hnd;
    logic              accept;
    logic              out_free;
    logic [TIME_W-1:0] in_time;
    logic [HS_W-1:0]   in_hnd;

    // Logical slot j of the sorted list lives at head + j, wrapped.
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [PTR_W-1:0] j);
        logic [PTR_W:0] s;
        s = {1'b0, head} + {1'b0, j};
        if (s >= DEPTH_P)
        begin
            s = s - DEPTH_P;
        end
        return s[PTR_W-1:0];
    endfunction

    tomq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_time  = rd_data[TIME_W-1:0];
    assign rd_hnd   = rd_data[WORD_W-1:TIME_W];
    assign in_time  = s_tdata[TIME_W-1:0];
    assign in_hnd   = s_tdata[TIME_W +: HS_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == CMD_INSERT)
                    begin
                        if (count_reg == FULL_CNT || count_reg == '0)
                        begin
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_INS_CMP;
                        end
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_RESULT : ST_REM_OUT;
                    end
                end
            end
            ST_INS_CMP:
            begin
                if (rd_time > key_reg)
                begin
                    state_next = (idx_reg == '0) ? ST_INS_PUT : ST_INS_CMP;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_INS_PUT: state_next = ST_RESULT;
            ST_REM_OUT: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        hnd_next        = hnd_reg;
        res_status_next = res_status_reg;
        res_time_next   = res_time_reg;
        res_handle_next = res_handle_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        wr_en           = 1'b0;
        wr_addr         = phys(head_reg, idx_reg + PTR_W'(1));
        wr_data         = {hnd_reg, key_reg};
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next        = in_time;
                    hnd_next        = in_hnd;
                    res_status_next = STATUS_OK;
                    res_time_next   = '0;
                    res_handle_next = '0;
                    if (s_tuser[0] == CMD_INSERT)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_reg;
                            wr_data    = {in_hnd, in_time};
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            // Start the walk at the latest entry.
                            rd_en    = 1'b1;
                            idx_next = PTR_W'(count_reg - CNT_W'(1));
                            rd_addr  = phys(head_reg, PTR_W'(count_reg - CNT_W'(1)));
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = head_reg;
                        end
                    end
                end
            end
            ST_INS_CMP:
            begin
                if (rd_time > key_reg)
                begin
                    // Later entry moves up one slot; fetch the one before it.
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    if (idx_reg != '0)
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg - PTR_W'(1);
                        rd_addr  = phys(head_reg, idx_reg - PTR_W'(1));
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                count_next = count_reg + CNT_W'(1);
            end
            ST_REM_OUT:
            begin
                res_time_next   = rd_time;
                res_handle_next = HANDLE_W'(rd_hnd);
                head_next       = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
                count_next      = count_reg - CNT_W'(1);
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {2'b00, COUNT_W'(count_reg), count_reg == '0,
                                    res_handle_reg, res_time_reg};
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        hnd_reg        <= hnd_next;
        res_status_reg <= res_status_next;
        res_time_reg   <= res_time_next;
        res_handle_reg <= res_handle_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds queue depth");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS_CMP |-> ({1'b0, idx_reg} < (PTR_W + 1)'(count_reg)))
        else $error("insert walk index outside held entries");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !accept) |-> !wr_en)
        else $error("memory written while idle");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STATUS_FULL) |-> (m_tdata[53:49] == COUNT_W'(QUEUE_DEPTH)))
        else $error("full status reported with queue not full");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STATUS_EMPTY) |-> (m_tdata[48] && m_tdata[47:0] == '0))
        else $error("empty status with nonzero entry data");

endmodule
